/* design/cidf_pkg.sv */
// ----------------------------------------------------------------------------
// cidf_pkg: shared types and constants of the CAN identifier filter table
// Table size, field widths, mode codes and the item/record structs.
// ----------------------------------------------------------------------------
package cidf_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int ID_W   = 11;
  localparam int WORD_W = 64;
  localparam int MODE_W = 2;

  // item mode codes
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // input item as seen by the search engine
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] word;
  } item_t;

  // log record
  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [ID_W-1:0]   logged_id;
    logic [WORD_W-1:0] logged_word;
    logic              new_entry;
    logic              table_full;
  } rec_t;

endpackage

/* design/can_id_filter_last_value_table_unit.sv */
// ----------------------------------------------------------------------------
// can_id_filter_last_value_table_unit: CAN identifier filter table
// Looks up received frames in a table of accepted identifiers, learns new
// ones on request and emits one log record per matched, learned or full-table frame.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   in      | in_valid/in_ready, mode,id,b* | input
//   out     | out_valid/out_ready, record   | output
//   cfg     | cfg_valid/cfg_ready, record_all| input
//
// Load, clear and unused-mode items finish in the accept cycle. A frame walks
// the filled slots, one compare per cycle on the identifier RAM read port,
// then logs a hit, or on a miss learns, flags a full table or stays silent.
// A finished record waits in the output register; the sequencer holds
// in its record state until that register frees. Reset (rst_n low,
// synchronous) empties the table and clears record_all.
// ----------------------------------------------------------------------------
module can_id_filter_last_value_table_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_record_all,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cidf_pkg::MODE_W-1:0]     in_mode,
  input  logic [cidf_pkg::ID_W-1:0]       in_frame_id,
  input  logic [7:0]                      in_byte0,
  input  logic [7:0]                      in_byte1,
  input  logic [7:0]                      in_byte2,
  input  logic [7:0]                      in_byte3,
  input  logic [7:0]                      in_byte4,
  input  logic [7:0]                      in_byte5,
  input  logic [7:0]                      in_byte6,
  input  logic [7:0]                      in_byte7,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cidf_pkg::IDX_W-1:0]      out_entry_index,
  output logic [cidf_pkg::ID_W-1:0]       out_logged_id,
  output logic [cidf_pkg::WORD_W-1:0]     out_logged_word,
  output logic                            out_new_entry,
  output logic                            out_table_full
);

  logic            record_all_r;
  logic            out_valid_r;
  cidf_pkg::rec_t  out_r;
  cidf_pkg::item_t item;
  cidf_pkg::rec_t  rec;
  logic            rec_valid;
  logic            rec_ready;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_all_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      record_all_r <= cfg_record_all;
    end
  end

  // pack payload big-endian, byte0 on top
  assign item.mode = in_mode;
  assign item.id   = in_frame_id;
  assign item.word = {in_byte0, in_byte1, in_byte2, in_byte3,
                      in_byte4, in_byte5, in_byte6, in_byte7};

  cidf_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .record_all (record_all_r),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  // output register
  assign rec_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_ready) begin
      out_valid_r <= rec_valid;
    end
    if (rec_valid && rec_ready) begin
      out_r <= rec;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_r.entry_index;
  assign out_logged_id   = out_r.logged_id;
  assign out_logged_word = out_r.logged_word;
  assign out_new_entry   = out_r.new_entry;
  assign out_table_full  = out_r.table_full;

endmodule

/* design/cidf_ram.sv */
// ----------------------------------------------------------------------------
// cidf_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cidf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/cidf_search.sv */
// ----------------------------------------------------------------------------
// cidf_search: identifier table sequencer
// Holds the identifier RAM and the fill count. Loads and clears finish in
// the accept cycle; a frame walks the filled slots, one compare per cycle,
// then matches, learns, reports a full table or drops silently.
// ----------------------------------------------------------------------------
module cidf_search (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            record_all,
  input  logic            item_valid,
  output logic            item_ready,
  input  cidf_pkg::item_t item,
  output logic            rec_valid,
  input  logic            rec_ready,
  output cidf_pkg::rec_t  rec
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_REC
  } state_t;

  state_t                          state_r, state_nxt;
  cidf_pkg::item_t                 item_r, item_nxt;
  logic [cidf_pkg::IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [cidf_pkg::CNT_W-1:0]      count_r, count_nxt;
  cidf_pkg::rec_t                  rec_r, rec_nxt;

  logic                            accept;
  logic                            rd_en;
  logic [cidf_pkg::IDX_W-1:0]      rd_addr;
  logic [cidf_pkg::ID_W-1:0]       rd_data;
  logic                            wr_en;
  logic [cidf_pkg::IDX_W-1:0]      wr_addr;
  logic [cidf_pkg::ID_W-1:0]       wr_data;
  logic                            last_slot;
  logic                            full;

  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign rec_valid  = (state_r == ST_REC);
  assign rec        = rec_r;

  assign full      = (count_r == cidf_pkg::CNT_W'(cidf_pkg::TABLE_DEPTH));
  assign last_slot = ((cidf_pkg::CNT_W'(cmp_idx_r) + cidf_pkg::CNT_W'(1)) == count_r);

  // identifier store
  cidf_ram #(
    .DEPTH (cidf_pkg::TABLE_DEPTH),
    .WIDTH (cidf_pkg::ID_W)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state, RAM ports and record
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    cmp_idx_nxt = cmp_idx_r;
    count_nxt   = count_r;
    rec_nxt     = rec_r;
    rd_en       = 1'b0;
    rd_addr     = cmp_idx_r + cidf_pkg::IDX_W'(1);
    wr_en       = 1'b0;
    wr_addr     = count_r[cidf_pkg::IDX_W-1:0];
    wr_data     = item_r.id;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt = item;
          case (item.mode)
            cidf_pkg::MODE_LOAD: begin
              // append filter id, ignored when full
              if (!full) begin
                wr_en     = 1'b1;
                wr_data   = item.id;
                count_nxt = count_r + cidf_pkg::CNT_W'(1);
              end
            end
            cidf_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            cidf_pkg::MODE_FRAME: begin
              // start the walk at slot 0
              cmp_idx_nxt = '0;
              if (count_r == '0) begin
                state_nxt = ST_MISS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // rd_data holds the id of slot cmp_idx_r
        if (rd_data == item_r.id) begin
          rec_nxt.entry_index = cmp_idx_r;
          rec_nxt.logged_id   = item_r.id;
          rec_nxt.logged_word = item_r.word;
          rec_nxt.new_entry   = 1'b0;
          rec_nxt.table_full  = 1'b0;
          state_nxt           = ST_REC;
        end else if (last_slot) begin
          state_nxt = ST_MISS;
        end else begin
          rd_en       = 1'b1;
          cmp_idx_nxt = cmp_idx_r + cidf_pkg::IDX_W'(1);
        end
      end

      ST_MISS: begin
        rec_nxt.logged_id = item_r.id;
        if (!record_all) begin
          state_nxt = ST_IDLE;
        end else if (full) begin
          rec_nxt.entry_index = '0;
          rec_nxt.logged_word = '0;
          rec_nxt.new_entry   = 1'b0;
          rec_nxt.table_full  = 1'b1;
          state_nxt           = ST_REC;
        end else begin
          // learn the new identifier
          wr_en               = 1'b1;
          count_nxt           = count_r + cidf_pkg::CNT_W'(1);
          rec_nxt.entry_index = count_r[cidf_pkg::IDX_W-1:0];
          rec_nxt.logged_word = item_r.word;
          rec_nxt.new_entry   = 1'b1;
          rec_nxt.table_full  = 1'b0;
          state_nxt           = ST_REC;
        end
      end

      ST_REC: begin
        if (rec_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    rec_r     <= rec_nxt;
  end

endmodule

/* verif/can_id_filter_last_value_table_unit_test.sv */
// ----------------------------------------------------------------------------
// can_id_filter_last_value_table_unit_test: CAN identifier filter table bench
// Drives frame, load, clear and spare-mode items with random handshake gaps.
// A local table model predicts every log record, and a monitor compares each
// record field by field against the oldest prediction. Covers lookup with and
// without learning, duplicates, a full table and long random traffic.
// ----------------------------------------------------------------------------
module can_id_filter_last_value_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // unused fourth mode code, ignored by the block
  localparam logic [cidf_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  // cycles to let a silent frame finish its table walk
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam longint      RUN_LIMIT_NS  = 5_000_000;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic                        cfg_record_all;
  logic                        in_valid;
  logic                        in_ready;
  logic [cidf_pkg::MODE_W-1:0] in_mode;
  logic [cidf_pkg::ID_W-1:0]   in_frame_id;
  logic [7:0]                  in_byte0, in_byte1, in_byte2, in_byte3;
  logic [7:0]                  in_byte4, in_byte5, in_byte6, in_byte7;
  logic                        out_valid;
  logic                        out_ready;
  logic [cidf_pkg::IDX_W-1:0]  out_entry_index;
  logic [cidf_pkg::ID_W-1:0]   out_logged_id;
  logic [cidf_pkg::WORD_W-1:0] out_logged_word;
  logic                        out_new_entry;
  logic                        out_table_full;

  // predicted table contents and setting
  logic [cidf_pkg::ID_W-1:0]   id_tab [cidf_pkg::TABLE_DEPTH];
  logic [cidf_pkg::WORD_W-1:0] word_tab [cidf_pkg::TABLE_DEPTH];
  int unsigned                 fill_count;
  logic                        learn_new;

  // log records still owed by the block
  cidf_pkg::rec_t log_queue [$];

  // ids sent recently, reused so that frames hit the table
  logic [cidf_pkg::ID_W-1:0] id_pool [$];

  bit          no_idle;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned hits_seen;
  int unsigned learned_seen;
  int unsigned full_seen;

  can_id_filter_last_value_table_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_record_all  (cfg_record_all),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_frame_id     (in_frame_id),
    .in_byte0        (in_byte0),
    .in_byte1        (in_byte1),
    .in_byte2        (in_byte2),
    .in_byte3        (in_byte3),
    .in_byte4        (in_byte4),
    .in_byte5        (in_byte5),
    .in_byte6        (in_byte6),
    .in_byte7        (in_byte7),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_index (out_entry_index),
    .out_logged_id   (out_logged_id),
    .out_logged_word (out_logged_word),
    .out_new_entry   (out_new_entry),
    .out_table_full  (out_table_full)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap drawn per item; zero during no-idle stretches
  function automatic int unsigned draw_gap();
    if (no_idle)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  // table model: returns 1 when the item produces a log record
  function automatic bit predict_log(input cidf_pkg::item_t it, output cidf_pkg::rec_t rec);
    rec = '0;
    case (it.mode)
      cidf_pkg::MODE_LOAD: begin
        if (fill_count < cidf_pkg::TABLE_DEPTH) begin
          id_tab[fill_count]   = it.id;
          word_tab[fill_count] = '0;
          fill_count++;
        end
        return 1'b0;
      end
      cidf_pkg::MODE_CLEAR: begin
        fill_count = 0;
        return 1'b0;
      end
      cidf_pkg::MODE_FRAME: begin
        // lowest matching slot wins
        for (int s = 0; s < fill_count; s++) begin
          if (id_tab[s] == it.id) begin
            word_tab[s]     = it.word;
            rec.entry_index = s[cidf_pkg::IDX_W-1:0];
            rec.logged_id   = it.id;
            rec.logged_word = it.word;
            return 1'b1;
          end
        end
        if (!learn_new)
          return 1'b0;
        rec.logged_id = it.id;
        if (fill_count >= cidf_pkg::TABLE_DEPTH) begin
          rec.table_full = 1'b1;
          return 1'b1;
        end
        id_tab[fill_count]   = it.id;
        word_tab[fill_count] = it.word;
        rec.entry_index      = fill_count[cidf_pkg::IDX_W-1:0];
        rec.logged_word      = it.word;
        rec.new_entry        = 1'b1;
        fill_count++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name,
                                      input logic [cidf_pkg::WORD_W-1:0] want,
                                      input logic [cidf_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // predict on accepted items, check accepted records
  always @(posedge clk) begin : log_monitor
    cidf_pkg::item_t it;
    cidf_pkg::rec_t  rec;
    cidf_pkg::rec_t  want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        learn_new = cfg_record_all;
      if (in_valid && in_ready) begin
        it.mode = in_mode;
        it.id   = in_frame_id;
        it.word = {in_byte0, in_byte1, in_byte2, in_byte3,
                   in_byte4, in_byte5, in_byte6, in_byte7};
        if (predict_log(it, rec))
          log_queue = {log_queue, rec};
      end
      if (out_valid && out_ready) begin
        if (log_queue.size() == 0) begin
          $error("log record with no item owing it: id 0x%0h", out_logged_id);
          fail_count++;
        end else begin
          want = log_queue.pop_front();
          check_field("entry_index", want.entry_index, out_entry_index);
          check_field("logged_id", want.logged_id, out_logged_id);
          check_field("logged_word", want.logged_word, out_logged_word);
          check_field("new_entry", want.new_entry, out_new_entry);
          check_field("table_full", want.table_full, out_table_full);
          if (want.table_full)
            full_seen++;
          else if (want.new_entry)
            learned_seen++;
          else
            hits_seen++;
        end
      end
    end
  end

  // record sink: stalls a drawn number of cycles once a record shows up
  initial begin : record_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall     = draw_gap();
      out_ready = (stall == 0);
      @(posedge clk);
      while (out_valid !== 1'b1)
        @(posedge clk);
      if (stall != 0) begin
        repeat (stall - 1) @(posedge clk);
        @(negedge clk);
        out_ready = 1'b1;
        do @(posedge clk); while (out_valid !== 1'b1);
      end
      @(negedge clk);
    end
  end

  // send one item; called and returns at a falling edge
  task automatic send_item(input logic [cidf_pkg::MODE_W-1:0] m,
                           input logic [cidf_pkg::ID_W-1:0] id,
                           input logic [cidf_pkg::WORD_W-1:0] w);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk);
    in_mode     = m;
    in_frame_id = id;
    {in_byte0, in_byte1, in_byte2, in_byte3,
     in_byte4, in_byte5, in_byte6, in_byte7} = w;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic wait_drain();
    while (log_queue.size() != 0)
      @(negedge clk);
  endtask

  // write record_all with the block idle
  task automatic write_record_all(input logic v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_record_all = v;
    cfg_valid      = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // lookup only, record_all at its reset value
  task automatic test_filter_lookup();
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(5), {$urandom, $urandom}); // empty table
    send_item(cidf_pkg::MODE_LOAD, '0, '0);
    send_item(cidf_pkg::MODE_LOAD, '1, '0);
    send_item(cidf_pkg::MODE_LOAD, '0, '0);                       // duplicate id
    send_item(cidf_pkg::MODE_LOAD, cidf_pkg::ID_W'(11'h555), '0);
    send_item(cidf_pkg::MODE_FRAME, '0, '1);                      // lowest slot of dup
    send_item(cidf_pkg::MODE_FRAME, '1, '0);
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(11'h555), 64'h0123_4567_89ab_cdef);
    send_item(cidf_pkg::MODE_FRAME, '0, 64'h8000_0000_0000_0001);
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(100), {$urandom, $urandom}); // silent
    send_item(MODE_SPARE, '1, '1);                                // ignored
    send_item(cidf_pkg::MODE_CLEAR, '0, '0);
    send_item(cidf_pkg::MODE_FRAME, '0, '1);                      // cleared, silent
  endtask

  // learning of unknown ids
  task automatic test_learning();
    write_record_all(1'b1);
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(7), {$urandom, $urandom}); // slot 0
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(7), {$urandom, $urandom}); // hit
    send_item(cidf_pkg::MODE_FRAME, '1, '1);                      // learned at slot 1
    send_item(cidf_pkg::MODE_LOAD, cidf_pkg::ID_W'(9), '0);
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(9), {$urandom, $urandom});
    send_item(cidf_pkg::MODE_CLEAR, '0, '0);
    send_item(cidf_pkg::MODE_FRAME, '1, '0);
  endtask

  // fill every slot, then overflow
  task automatic test_table_full();
    logic [cidf_pkg::ID_W-1:0] last_id;
    write_record_all(1'b1);
    last_id = '0;
    send_item(cidf_pkg::MODE_CLEAR, '0, '0);
    for (int k = 0; k < 40; k++)
      send_item(cidf_pkg::MODE_LOAD, cidf_pkg::ID_W'(k * 16 + $urandom_range(0, 15)), '0);
    for (int k = 0; k < cidf_pkg::TABLE_DEPTH - 40; k++) begin
      last_id = cidf_pkg::ID_W'(1024 + k * 32 + $urandom_range(0, 31));
      send_item(cidf_pkg::MODE_FRAME, last_id, {$urandom, $urandom});
    end
    send_item(cidf_pkg::MODE_LOAD, cidf_pkg::ID_W'(1), '0);       // no room, ignored
    send_item(cidf_pkg::MODE_FRAME, '1, {$urandom, $urandom});    // dropped, flagged
    send_item(cidf_pkg::MODE_FRAME, last_id, '1);                 // hit in top slot
    write_record_all(1'b0);
    send_item(cidf_pkg::MODE_FRAME, cidf_pkg::ID_W'(2046), '0);   // full, not learning
    send_item(cidf_pkg::MODE_CLEAR, '0, '0);
  endtask

  function automatic logic [cidf_pkg::ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55 && id_pool.size() != 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    if (r < 85)
      return cidf_pkg::ID_W'($urandom_range(0, 15));
    if (r < 90)
      return '1;
    return cidf_pkg::ID_W'($urandom_range(0, 2047));
  endfunction

  task automatic run_phase(input logic learn, input int unsigned clear_permille);
    int unsigned                 done_cnt;
    int unsigned                 r;
    logic [cidf_pkg::MODE_W-1:0] m;
    logic [cidf_pkg::ID_W-1:0]   id;
    logic [cidf_pkg::WORD_W-1:0] w;
    write_record_all(learn);
    done_cnt = 0;
    while (done_cnt < PHASE_ITEMS) begin
      if (done_cnt % 40 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      // now and then hold off until every record is back
      if ($urandom_range(0, 99) == 0)
        wait_drain();
      r = $urandom_range(0, 999);
      if (r < clear_permille)
        m = cidf_pkg::MODE_CLEAR;
      else if (r < clear_permille + 20)
        m = MODE_SPARE;
      else if (r < clear_permille + 180)
        m = cidf_pkg::MODE_LOAD;
      else
        m = cidf_pkg::MODE_FRAME;
      id = pick_id();
      case ($urandom_range(0, 15))
        0:       w = '0;
        1:       w = '1;
        default: w = {$urandom, $urandom};
      endcase
      send_item(m, id, w);
      if (m == cidf_pkg::MODE_CLEAR) begin
        id_pool.delete();
      end else if (m != MODE_SPARE) begin
        id_pool = {id_pool, id};
        if (id_pool.size() > 96)
          void'(id_pool.pop_front());
        done_cnt++;
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(1'b0, 30);
    run_phase(1'b1, 20);
    run_phase(1'b1, 0);
    run_phase(1'b0, 30);
    run_phase(1'b1, 10);
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_record_all = 1'b0;
    in_valid       = 1'b0;
    in_mode        = cidf_pkg::MODE_FRAME;
    in_frame_id    = '0;
    {in_byte0, in_byte1, in_byte2, in_byte3,
     in_byte4, in_byte5, in_byte6, in_byte7} = '0;
    fill_count     = 0;
    learn_new      = 1'b0;
    no_idle        = 1'b0;
    fail_count     = 0;
    items_sent     = 0;
    hits_seen      = 0;
    learned_seen   = 0;
    full_seen      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_filter_lookup();
    test_learning();
    test_table_full();
    test_random_traffic();

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (log_queue.size() != 0) begin
      $error("%0d log records never arrived", log_queue.size());
      fail_count++;
    end
    $display("Sent %0d items through lookup, learning, full-table and random phases.",
             items_sent);
    $display("Checked %0d hits, %0d learned entries and %0d full-table drops.",
             hits_seen, learned_seen, full_seen);
    if (fail_count == 0)
      $display("can_id_filter_last_value_table_unit_test: PASS");
    else
      $display("can_id_filter_last_value_table_unit_test: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $error("run did not finish in time, %0d records outstanding", log_queue.size());
    $display("can_id_filter_last_value_table_unit_test: FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/cidf_pkg.sv
design/cidf_ram.sv
design/cidf_search.sv
design/can_id_filter_last_value_table_unit.sv
verif/can_id_filter_last_value_table_unit_test.sv
